// ===== sv/ale_pkg.sv =====
package ale_pkg;

  localparam logic [7:0] NewlineByte   = 8'd10;
  localparam logic [7:0] CommentByte   = 8'd59;
  localparam logic [7:0] DigitLowExcl  = 8'd47;
  localparam logic [7:0] DigitHighExcl = 8'd58;
  localparam logic [7:0] UpperLowExcl  = 8'd64;
  localparam logic [7:0] UpperHighExcl = 8'd91;
  localparam int unsigned OpcodeShift  = 24;

  typedef enum logic [2:0] {
    FMT_NONE,
    FMT_IMM,
    FMT_AB_IMM,
    FMT_A_IMM,
    FMT_AB,
    FMT_ABC
  } fmt_t;

  typedef struct packed {
    logic       known;
    logic [7:0] opcode;
    fmt_t       fmt;
  } mnem_t;

  // One encoded line waiting for the output side
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] imm;
    logic        two;
  } line_res_t;

  function automatic mnem_t lookup_mnem(input logic [23:0] text);
    mnem_t m;
    m.known = 1'b1;
    case (text)
      "NOP": begin m.opcode = 8'd0;  m.fmt = FMT_NONE;   end
      "JMP": begin m.opcode = 8'd1;  m.fmt = FMT_IMM;    end
      "JE ": begin m.opcode = 8'd2;  m.fmt = FMT_AB_IMM; end
      "JNE": begin m.opcode = 8'd3;  m.fmt = FMT_AB_IMM; end
      "JG ": begin m.opcode = 8'd4;  m.fmt = FMT_AB_IMM; end
      "JGE": begin m.opcode = 8'd5;  m.fmt = FMT_AB_IMM; end
      "JL ": begin m.opcode = 8'd6;  m.fmt = FMT_AB_IMM; end
      "JLE": begin m.opcode = 8'd7;  m.fmt = FMT_AB_IMM; end
      "MOV": begin m.opcode = 8'd8;  m.fmt = FMT_A_IMM;  end
      "CPY": begin m.opcode = 8'd9;  m.fmt = FMT_AB;     end
      "LDA": begin m.opcode = 8'd10; m.fmt = FMT_AB;     end
      "STO": begin m.opcode = 8'd11; m.fmt = FMT_AB;     end
      "SHL": begin m.opcode = 8'd12; m.fmt = FMT_ABC;    end
      "SHR": begin m.opcode = 8'd13; m.fmt = FMT_ABC;    end
      "NOT": begin m.opcode = 8'd14; m.fmt = FMT_AB;     end
      "AND": begin m.opcode = 8'd15; m.fmt = FMT_ABC;    end
      "OR ": begin m.opcode = 8'd16; m.fmt = FMT_ABC;    end
      "XOR": begin m.opcode = 8'd17; m.fmt = FMT_ABC;    end
      "ADD": begin m.opcode = 8'd18; m.fmt = FMT_ABC;    end
      "MUL": begin m.opcode = 8'd19; m.fmt = FMT_ABC;    end
      "DIV": begin m.opcode = 8'd20; m.fmt = FMT_ABC;    end
      "MOD": begin m.opcode = 8'd21; m.fmt = FMT_ABC;    end
      default: begin
        m.known  = 1'b0;
        m.opcode = 8'd0;
        m.fmt    = FMT_NONE;
      end
    endcase
    return m;
  endfunction

endpackage

// ===== sv/ale_byte_if.sv =====
interface ale_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// ===== sv/ale_word_if.sv =====
interface ale_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic        last_word;

  modport source (output valid, output code_word, output last_word, input ready);
  modport sink (input valid, input code_word, input last_word, output ready);
endinterface

// ===== sv/assembly_line_encoder_unit.sv =====
// A newline that ends a line with a known mnemonic queues its encoded line; its first word shows once it is the head.
// Throughput: one text byte per cycle unless input stalls; a line with a known mnemonic gives one or
// two words, one word per cycle while the sink is ready. A two-entry line result queue sits before
// the output, so input stalls only when both entries hold lines the sink has not yet taken.
// Reset (rst, synchronous, active high) clears line state, mnemonic, slots and the queue.
module assembly_line_encoder_unit
  import ale_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ale_byte_if.sink    text,
  ale_word_if.source  code
);

  logic [1:0]  column, column_next;
  logic [7:0]  mnem_chars [3];
  logic [7:0]  mnem_chars_next [3];
  logic [31:0] immediate_acc, immediate_acc_next;
  logic [4:0]  reg_slots [3];
  logic [4:0]  reg_slots_next [3];
  logic [1:0]  reg_count, reg_count_next;
  logic        in_comment, in_comment_next;

  line_res_t   head, slot1, res_new;
  logic        head_valid, slot1_valid;
  logic        phase;

  logic        accept, push, pop;
  logic [7:0]  b;
  mnem_t       mnem;
  logic [31:0] word;

  assign b      = text.text_byte;
  assign accept = text.valid && text.ready;
  assign text.ready = !slot1_valid;

  assign mnem = lookup_mnem({mnem_chars[0], mnem_chars[1], mnem_chars[2]});

  // Instruction word for the current line, fields masked by format
  always_comb begin
    word = {mnem.opcode, 24'd0};
    if (mnem.fmt == FMT_AB_IMM || mnem.fmt == FMT_A_IMM || mnem.fmt == FMT_AB ||
        mnem.fmt == FMT_ABC) begin
      word[23:16] = {3'd0, reg_slots[0]};
    end
    if (mnem.fmt == FMT_AB_IMM || mnem.fmt == FMT_AB || mnem.fmt == FMT_ABC) begin
      word[15:8] = {3'd0, reg_slots[1]};
    end
    if (mnem.fmt == FMT_ABC) begin
      word[7:0] = {3'd0, reg_slots[2]};
    end
    res_new.word = word;
    res_new.imm  = immediate_acc;
    res_new.two  = (mnem.fmt == FMT_IMM || mnem.fmt == FMT_AB_IMM || mnem.fmt == FMT_A_IMM);
  end

  assign push = accept && (b == NewlineByte) && (column == 2'd3) && mnem.known;

  // Line state update
  always_comb begin
    column_next        = column;
    mnem_chars_next    = mnem_chars;
    immediate_acc_next = immediate_acc;
    reg_slots_next     = reg_slots;
    reg_count_next     = reg_count;
    in_comment_next    = in_comment;
    if (accept) begin
      if (b == NewlineByte) begin
        column_next        = 2'd0;
        immediate_acc_next = 32'd0;
        reg_count_next     = 2'd0;
        in_comment_next    = 1'b0;
      end else if (column != 2'd3) begin
        mnem_chars_next[column] = b;
        column_next             = column + 2'd1;
      end else if (!in_comment) begin
        if (b == CommentByte) begin
          in_comment_next = 1'b1;
        end else if (b > DigitLowExcl && b < DigitHighExcl) begin
          immediate_acc_next = (immediate_acc << 3) + (immediate_acc << 1)
                             + {28'd0, 4'(b - (DigitLowExcl + 8'd1))};
        end else if (b > UpperLowExcl && b < UpperHighExcl) begin
          if (reg_count != 2'd3) begin
            reg_slots_next[reg_count] = 5'(b - (UpperLowExcl + 8'd1));
            reg_count_next            = reg_count + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= 2'd0;
      mnem_chars    <= '{default: 8'd0};
      immediate_acc <= 32'd0;
      reg_slots     <= '{default: 5'd0};
      reg_count     <= 2'd0;
      in_comment    <= 1'b0;
    end else begin
      column        <= column_next;
      mnem_chars    <= mnem_chars_next;
      immediate_acc <= immediate_acc_next;
      reg_slots     <= reg_slots_next;
      reg_count     <= reg_count_next;
      in_comment    <= in_comment_next;
    end
  end

  // Output side: head entry drives the port, phase picks the immediate word
  assign code.valid     = head_valid;
  assign code.code_word = phase ? head.imm : head.word;
  assign code.last_word = !head.two || phase;
  assign pop            = head_valid && code.ready && code.last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      slot1_valid <= 1'b0;
      phase       <= 1'b0;
    end else begin
      if (pop) begin
        phase <= 1'b0;
      end else if (head_valid && code.ready) begin
        phase <= 1'b1;
      end
      if (pop) begin
        head_valid  <= slot1_valid || push;
        slot1_valid <= slot1_valid && push;
      end else if (push) begin
        if (!head_valid) begin
          head_valid <= 1'b1;
        end else begin
          slot1_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (slot1_valid) begin
        head <= slot1;
      end else if (push) begin
        head <= res_new;
      end
      if (slot1_valid && push) begin
        slot1 <= res_new;
      end
    end else if (push) begin
      if (!head_valid) begin
        head <= res_new;
      end else begin
        slot1 <= res_new;
      end
    end
  end

  // Queue order: the second entry never holds a line without a head
  assert property (@(posedge clk) disable iff (rst) slot1_valid |-> head_valid)
    else $error("queue second entry valid without head");

  // The immediate word is only shown for a two-word line
  assert property (@(posedge clk) disable iff (rst) phase |-> (head_valid && head.two))
    else $error("immediate phase on a one-word line");

  // A newline clears the line state
  assert property (@(posedge clk) disable iff (rst)
    (accept && b == NewlineByte) |=> (column == 2'd0 && reg_count == 2'd0 &&
                                      immediate_acc == 32'd0 && !in_comment))
    else $error("line state not cleared at newline");

  // A finished line always lands in the queue
  assert property (@(posedge clk) disable iff (rst) push |=> head_valid)
    else $error("encoded line lost");

endmodule
